>>> design/bpcb_pkg.sv
// Shared types and constants for the button press classifier and LED driver.
`default_nettype none
package bpcb_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int ADDR_WIDTH  = 4;
  localparam int DATA_WIDTH  = 32;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [CFG_WIDTH-1:0] MIN_PRESS_RST  = CFG_WIDTH'(3);
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST = CFG_WIDTH'(1000);
  localparam logic [CFG_WIDTH-1:0] HOLD_LIMIT_RST = CFG_WIDTH'(60000);
  localparam logic [CFG_WIDTH-1:0] BLINK_RST      = CFG_WIDTH'(50);

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_ON   = 2'd1,
    MODE_OFF  = 2'd2,
    MODE_LONG = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MIN_PRESS  = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_HOLD_LIMIT = 2'd2,
    REG_BLINK      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] min_press;
    logic [CFG_WIDTH-1:0] long_press;
    logic [CFG_WIDTH-1:0] hold_limit;
    logic [CFG_WIDTH-1:0] blink;
  } bpcb_cfg_t;

  typedef struct packed {
    logic                   pressed;
    logic [COUNT_WIDTH-1:0] hold_count;
    logic                   toggle;
    mode_t                  mode;
    logic [COUNT_WIDTH-1:0] blink_count;
    logic                   toggle_led;
    logic                   blink_led;
  } bpcb_state_t;

endpackage
`default_nettype wire

>>> design/bpcb_step.sv
// Next-state logic for one sample tick: press classification, then both LEDs.
`default_nettype none
module bpcb_step (
  input  wire logic                 level,
  input  wire bpcb_pkg::bpcb_cfg_t   cfg,
  input  wire bpcb_pkg::bpcb_state_t cur,
  output bpcb_pkg::bpcb_state_t     nxt
);
  import bpcb_pkg::*;

  logic [CMP_WIDTH-1:0]   cap;
  logic [CMP_WIDTH-1:0]   hold_ext;
  logic [CMP_WIDTH-1:0]   hold_inc_ext;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic [COUNT_WIDTH-1:0] blink_inc;
  logic                   short_press;
  bpcb_state_t            cls;

  // hold counter caps at the smaller of hold_limit and the counter's full scale
  always_comb begin
    if (CMP_WIDTH'(cfg.hold_limit) > CMP_WIDTH'(COUNT_MAX)) begin
      cap = CMP_WIDTH'(COUNT_MAX);
    end else begin
      cap = CMP_WIDTH'(cfg.hold_limit);
    end
  end

  assign hold_ext     = CMP_WIDTH'(cur.hold_count);
  assign hold_inc     = (hold_ext < cap) ? cur.hold_count + 1'b1 : cur.hold_count;
  assign hold_inc_ext = CMP_WIDTH'(hold_inc);
  assign short_press  = (hold_ext > CMP_WIDTH'(cfg.min_press)) &&
                        (hold_ext < CMP_WIDTH'(cfg.long_press));

  always_comb begin
    cls = cur;
    if (!level) begin
      cls.pressed    = 1'b1;
      cls.hold_count = hold_inc;
      if (hold_inc_ext == CMP_WIDTH'(cfg.long_press)) begin
        cls.mode = MODE_LONG;
      end
    end else if (cur.pressed) begin
      if (short_press) begin
        cls.toggle = ~cur.toggle;
        cls.mode   = cur.toggle ? MODE_OFF : MODE_ON;
      end
      cls.pressed    = 1'b0;
      cls.hold_count = '0;
    end
  end

  assign blink_inc = (cls.blink_count != COUNT_MAX) ? cls.blink_count + 1'b1
                                                    : cls.blink_count;

  always_comb begin
    nxt = cls;
    if (cls.mode == MODE_ON) begin
      nxt.toggle_led = 1'b0;
    end else if (cls.mode == MODE_OFF) begin
      nxt.toggle_led = 1'b1;
    end
    if (cls.mode == MODE_LONG) begin
      if (CMP_WIDTH'(blink_inc) >= CMP_WIDTH'(cfg.blink)) begin
        nxt.blink_led   = ~cls.blink_led;
        nxt.blink_count = '0;
      end else begin
        nxt.blink_count = blink_inc;
      end
    end else begin
      nxt.blink_led   = 1'b1;
      nxt.blink_count = '0;
    end
  end

endmodule
`default_nettype wire

>>> design/button_press_classifier_blinker_core.sv
// Top level: request/result pipeline, register file and state of the press classifier.
// A request is captured in the input stage; its result is then registered for out_*.
// Throughput: one request per cycle, set by the next-state pass, unless out_stall holds.
// in_stall rises only when the input stage is full and the result register is held.
// Reset (rst_n low, synchronous): registers return to 3/1000/60000/50, mode none,
// both LEDs off, counters cleared, pipeline emptied.
`default_nettype none
module button_press_classifier_blinker_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_button_level,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_mode_code,
  output logic                                out_toggle_led_pin,
  output logic                                out_blink_led_pin,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bpcb_pkg::ADDR_WIDTH-1:0] paddr,
  input  wire logic [bpcb_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [bpcb_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                                pready
);
  import bpcb_pkg::*;

  bpcb_cfg_t   cfg_r;
  bpcb_state_t st_r;
  bpcb_state_t st_nxt;
  logic        s1_valid_r;
  logic        s1_level_r;
  logic        out_valid_r;
  logic [1:0]  mode_out_r;
  logic        tled_out_r;
  logic        bled_out_r;
  logic        s1_adv;
  logic        cfg_wr;
  reg_idx_t    reg_sel;

  // register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (reg_sel)
      REG_MIN_PRESS:  prdata = DATA_WIDTH'(cfg_r.min_press);
      REG_LONG_PRESS: prdata = DATA_WIDTH'(cfg_r.long_press);
      REG_HOLD_LIMIT: prdata = DATA_WIDTH'(cfg_r.hold_limit);
      REG_BLINK:      prdata = DATA_WIDTH'(cfg_r.blink);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_press  <= MIN_PRESS_RST;
      cfg_r.long_press <= LONG_PRESS_RST;
      cfg_r.hold_limit <= HOLD_LIMIT_RST;
      cfg_r.blink      <= BLINK_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_MIN_PRESS:  cfg_r.min_press  <= pwdata[CFG_WIDTH-1:0];
        REG_LONG_PRESS: cfg_r.long_press <= pwdata[CFG_WIDTH-1:0];
        REG_HOLD_LIMIT: cfg_r.hold_limit <= pwdata[CFG_WIDTH-1:0];
        REG_BLINK:      cfg_r.blink      <= pwdata[CFG_WIDTH-1:0];
        default:        ;
      endcase
    end
  end

  // input stage moves on whenever the result register is empty or being drained
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_level_r <= in_button_level;
    end
  end

  bpcb_step u_step (
    .level (s1_level_r),
    .cfg   (cfg_r),
    .cur   (st_r),
    .nxt   (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.pressed     <= 1'b0;
      st_r.hold_count  <= '0;
      st_r.toggle      <= 1'b0;
      st_r.mode        <= MODE_NONE;
      st_r.blink_count <= '0;
      st_r.toggle_led  <= 1'b1;
      st_r.blink_led   <= 1'b1;
    end else if (s1_valid_r && s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      mode_out_r <= st_nxt.mode;
      tled_out_r <= st_nxt.toggle_led;
      bled_out_r <= st_nxt.blink_led;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode_code      = mode_out_r;
  assign out_toggle_led_pin = tled_out_r;
  assign out_blink_led_pin  = bled_out_r;

  a_blink_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mode != MODE_LONG) |-> (st_r.blink_led && (st_r.blink_count == '0)))
    else $error("blink LED active outside long hold");

  a_hold_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.pressed |-> (st_r.hold_count == '0))
    else $error("hold count nonzero while released");

  a_toggle_led: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r.mode == MODE_ON) |-> !st_r.toggle_led) and
    ((st_r.mode == MODE_OFF) |-> st_r.toggle_led))
    else $error("toggle LED disagrees with mode");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> out_valid_r)
    else $error("request advanced without producing a result");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for button_press_classifier_blinker_core: paced requests, stalls, APB setup.
`default_nettype none
module tb_top;
  import bpcb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CAP    = 48;

  typedef struct {
    mode_t mode;
    logic  toggle_led;
    logic  blink_led;
  } led_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_button_level = 1'b1;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_mode_code;
  logic                  out_toggle_led_pin;
  logic                  out_blink_led_pin;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  button_press_classifier_blinker_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_button_level(in_button_level),
    .out_valid(out_valid), .out_stall(out_stall), .out_mode_code(out_mode_code),
    .out_toggle_led_pin(out_toggle_led_pin), .out_blink_led_pin(out_blink_led_pin),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // press classifier shadow: configuration and state at reset values
  logic [CFG_WIDTH-1:0]   min_press_q  = MIN_PRESS_RST;
  logic [CFG_WIDTH-1:0]   long_press_q = LONG_PRESS_RST;
  logic [CFG_WIDTH-1:0]   hold_limit_q = HOLD_LIMIT_RST;
  logic [CFG_WIDTH-1:0]   blink_q      = BLINK_RST;
  logic                   prs_flag  = 1'b0;
  logic [COUNT_WIDTH-1:0] hold_cnt  = '0;
  logic                   tog_bit   = 1'b0;
  mode_t                  mode_q    = MODE_NONE;
  logic [COUNT_WIDTH-1:0] blink_cnt = '0;
  logic                   tog_led   = 1'b1;
  logic                   blink_led = 1'b1;

  logic        pending_levels[$];
  led_result_t expected_leds[$];
  int          err_count = 0;
  int          cycles = 0;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic void step_press_model(input logic level);
    logic [COUNT_WIDTH-1:0] cap;
    led_result_t r;
    cap = (hold_limit_q > COUNT_MAX) ? COUNT_MAX : COUNT_WIDTH'(hold_limit_q);
    if (level == 1'b0) begin
      prs_flag = 1'b1;
      if (hold_cnt < cap) hold_cnt = hold_cnt + 1'b1;
      if (hold_cnt == long_press_q) mode_q = MODE_LONG;
    end else if (prs_flag) begin
      if (hold_cnt > min_press_q && hold_cnt < long_press_q) begin
        tog_bit = ~tog_bit;
        mode_q  = tog_bit ? MODE_ON : MODE_OFF;
      end
      prs_flag = 1'b0;
      hold_cnt = '0;
    end
    if (mode_q == MODE_ON) tog_led = 1'b0;
    else if (mode_q == MODE_OFF) tog_led = 1'b1;
    if (mode_q == MODE_LONG) begin
      if (blink_cnt < COUNT_MAX) blink_cnt = blink_cnt + 1'b1;
      if (blink_cnt >= blink_q) begin
        blink_led = ~blink_led;
        blink_cnt = '0;
      end
    end else begin
      blink_led = 1'b1;
      blink_cnt = '0;
    end
    r.mode       = mode_q;
    r.toggle_led = tog_led;
    r.blink_led  = blink_led;
    expected_leds.push_back(r);
  endfunction

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  // request driver
  int unsigned gap_left = 0;
  bit          drv_burst = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        step_press_model(in_button_level);
        if ($urandom_range(0, 39) == 0) drv_burst = ~drv_burst;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_levels.size() != 0) begin
          in_valid        <= 1'b1;
          in_button_level <= pending_levels.pop_front();
          gap_left        <= draw_wait(drv_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int unsigned stall_left = 0;
  bit          mon_burst = 1'b0;
  always @(posedge clk) begin : result_mon
    led_result_t want;
    int unsigned w;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_leds.size() == 0) begin
        flag_error($sformatf("result with nothing expected (mode %0d)", out_mode_code));
      end else begin
        want = expected_leds.pop_front();
        if (out_mode_code !== want.mode)
          flag_error($sformatf("mode_code got %0d want %0d", out_mode_code, want.mode));
        if (out_toggle_led_pin !== want.toggle_led)
          flag_error($sformatf("toggle_led_pin got %b want %b",
                               out_toggle_led_pin, want.toggle_led));
        if (out_blink_led_pin !== want.blink_led)
          flag_error($sformatf("blink_led_pin got %b want %b",
                               out_blink_led_pin, want.blink_led));
      end
      if ($urandom_range(0, 39) == 0) mon_burst = ~mon_burst;
      w = draw_wait(mon_burst);
      out_stall  <= (w != 0);
      stall_left <= w;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("button_press_classifier_blinker_core regression: fail");
      $finish;
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_WIDTH-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_WIDTH'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MIN_PRESS:  min_press_q  = val;
      REG_LONG_PRESS: long_press_q = val;
      REG_HOLD_LIMIT: hold_limit_q = val;
      REG_BLINK:      blink_q      = val;
      default: ;
    endcase
  endtask

  task automatic cfg_all(input int mn, input int lg, input int lim, input int bl);
    cfg_write(REG_MIN_PRESS, CFG_WIDTH'(mn));
    cfg_write(REG_LONG_PRESS, CFG_WIDTH'(lg));
    cfg_write(REG_HOLD_LIMIT, CFG_WIDTH'(lim));
    cfg_write(REG_BLINK, CFG_WIDTH'(bl));
  endtask

  task automatic push_hold(input int held, input int rel);
    repeat (held) pending_levels.push_back(1'b0);
    repeat (rel) pending_levels.push_back(1'b1);
  endtask

  task automatic wait_drained();
    while (pending_levels.size() != 0 || in_valid || expected_leds.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly press/release sequences aimed at the thresholds, some raw noise
  task automatic queue_press_traffic(input int budget, input bit end_pressed);
    int n, h, rel, sel, mn, lg;
    n  = 0;
    mn = int'(min_press_q);
    lg = int'(long_press_q);
    while (n < budget) begin
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
        rel = $urandom_range(1, 8);
        repeat (rel) pending_levels.push_back(1'($urandom_range(0, 1)));
        n += rel;
      end else begin
        case (sel)
          2:       h = mn;
          3:       h = mn + 1;
          4:       h = lg - 1;
          5:       h = lg;
          6:       h = lg + $urandom_range(0, 3 * int'(blink_q) + 3);
          default: h = $urandom_range(1, lg + 2);
        endcase
        if (h > HOLD_CAP || h < 0) h = $urandom_range(1, HOLD_CAP);
        rel = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
        push_hold(h, rel);
        n += h + rel;
      end
    end
    // leave a hold in progress across the next register change
    if (end_pressed) push_hold($urandom_range(2, 5), 0);
  endtask

  task automatic random_phase(input int mn, input int lg, input int lim, input int bl,
                              input int budget, input bit end_pressed);
    cfg_all(mn, lg, lim, bl);
    queue_press_traffic(budget, end_pressed);
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: a 4-tick hold beats the default minimum of 3
    push_hold(4, 1);
    wait_drained();

    // release with no press, hold at minimum, toggle, long hold with fast blink
    cfg_all(2, 6, 10, 1);
    push_hold(0, 1);
    push_hold(2, 1);
    push_hold(3, 1);
    push_hold(7, 1);
    wait_drained();

    // zero limit, zero long threshold, zero blink period
    cfg_all(0, 0, 0, 0);
    push_hold(0, 1);
    push_hold(3, 2);
    wait_drained();

    random_phase(1, 10, 20, 3, 110, 1'b1);
    random_phase(0, 5, 3, 1, 90, 1'b0);
    random_phase(4, 12, 65535, 65535, 110, 1'b0);
    // blink period drops below the accumulated count
    random_phase(65535, 65535, 65535, 7, 80, 1'b1);
    random_phase(2, 8, 8, 2, 100, 1'b0);
    random_phase(3, 1, 1, 4, 60, 1'b0);
    repeat (3)
      random_phase($urandom_range(0, 6), $urandom_range(1, 20), $urandom_range(1, 25),
                   $urandom_range(1, 6), 80, 1'($urandom_range(0, 1)));

    wait_drained();
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("button_press_classifier_blinker_core regression: pass");
    else
      $display("button_press_classifier_blinker_core regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
